[design/usbpds_pkg.sv]
// Shared types and constants for the USB printer descriptor scanner.
package usbpds_pkg;

  // Descriptor type codes and minimum lengths.
  localparam logic [7:0] TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
  localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
  localparam logic [7:0] EP_MIN_LEN     = 8'd7;
  localparam logic [7:0] HEADER_MIN_LEN = 8'd4;
  localparam logic [7:0] DESC_MIN_LEN   = 8'd2;

  // Endpoint attribute and address decoding.
  localparam logic [1:0] XFER_BULK  = 2'b10;
  localparam int         DIR_IN_BIT = 7;

  // Stream offsets of the configuration header.
  localparam logic [15:0] OFS_HEADER_LEN = 16'd0;
  localparam logic [15:0] OFS_TOTAL_LO   = 16'd2;
  localparam logic [15:0] OFS_TOTAL_HI   = 16'd3;
  localparam logic [15:0] OFS_WALK_BEGIN = 16'd4;
  localparam logic [15:0] OFS_MAX        = 16'hFFFF;

  // Captured body bytes at relative offsets 2 through 6.
  localparam int CAP_COUNT = 5;
  localparam int CAP_BASE  = 2;

  // Configuration register map.
  localparam int         CFG_INDEX_W        = 1;
  localparam int         CFG_DATA_W         = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_CLASS    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_SUBCLASS = 1'b1;
  localparam logic [7:0] MATCH_CLASS_RESET    = 8'd7;
  localparam logic [7:0] MATCH_SUBCLASS_RESET = 8'd1;

  typedef logic [CAP_COUNT-1:0][7:0] cap_t;

  // One scan result.
  typedef struct packed {
    logic        found;
    logic [7:0]  interface_number;
    logic [7:0]  bulk_out_address;
    logic [15:0] bulk_out_max_packet;
    logic [7:0]  bulk_in_address;
    logic [15:0] bulk_in_max_packet;
  } result_t;

endpackage

[design/usb_printer_descriptor_scanner_unit.sv]
// Top level of the USB printer descriptor scanner.
//
// Usage:
//   A configuration descriptor enters on the input channel one byte per
//   request (desc_byte), starting at offset zero, with last set on the final
//   byte. Each byte is parsed in the cycle it is accepted, so the block takes
//   one byte per cycle while in_stall is low. A byte marked last produces
//   one result request on the output channel: found, the interface number
//   and the first bulk OUT and bulk IN endpoints with their max packet
//   sizes, all zero when not found. Results pass through an output register
//   backed by one skid entry, so the input keeps flowing while a result
//   waits; in_stall rises only when both entries hold results that the
//   receiver has not taken. match_class and match_subclass are written
//   through the cfg port; the user must write them only while the block is
//   idle, which the block itself does not enforce. Synchronous reset clears
//   the stream state and both result entries, and sets the match registers
//   to the printer class (7) and subclass (1). After every last byte the
//   stream state returns to its reset value and the match registers are kept.
module usb_printer_descriptor_scanner_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Input byte channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         desc_byte,
  input  logic                               last,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic [7:0]                         interface_number,
  output logic [7:0]                         bulk_out_address,
  output logic [15:0]                        bulk_out_max_packet,
  output logic [7:0]                         bulk_in_address,
  output logic [15:0]                        bulk_in_max_packet,
  // Configuration write port.
  input  logic                               cfg_write,
  input  logic [usbpds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [usbpds_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [7:0] match_class;
  logic [7:0] match_subclass;

  // Stream state.
  logic [15:0]            byte_offset;
  logic [15:0]            total_length;
  logic [7:0]             header_length;
  logic [15:0]            descriptor_start;
  logic [7:0]             descriptor_length;
  logic [7:0]             descriptor_type;
  usbpds_pkg::cap_t       captured_fields;
  logic                   walk_stopped;
  logic                   iface_found;
  logic [7:0]             latched_iface;
  logic [7:0]             latched_out_ep;
  logic [15:0]            latched_out_mps;
  logic [7:0]             latched_in_ep;
  logic [15:0]            latched_in_mps;

  // Next values.
  logic [15:0]            byte_offset_next;
  logic [15:0]            total_length_next;
  logic [7:0]             header_length_next;
  logic [15:0]            descriptor_start_next;
  logic [7:0]             descriptor_length_next;
  logic [7:0]             descriptor_type_next;
  usbpds_pkg::cap_t       captured_fields_next;
  logic                   walk_stopped_next;
  logic                   iface_found_next;
  logic [7:0]             latched_iface_next;
  logic [7:0]             latched_out_ep_next;
  logic [15:0]            latched_out_mps_next;
  logic [7:0]             latched_in_ep_next;
  logic [15:0]            latched_in_mps_next;

  // Output buffering.
  usbpds_pkg::result_t    out_data;
  usbpds_pkg::result_t    skid_data;
  logic                   skid_valid;
  usbpds_pkg::result_t    result;

  logic accept;
  logic out_free;
  logic res_valid;

  // Walk decode signals.
  logic [16:0]            start_plus_len;
  logic [16:0]            offset_plus_one;
  logic [15:0]            rel;
  logic                   in_walk;
  logic                   rel_zero;
  logic                   rel_one;
  logic                   bad_length;
  logic                   desc_done;
  logic [7:0]             type_merged;
  usbpds_pkg::cap_t       cap_merged;
  logic [15:0]            ep_mps;

  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign res_valid = accept && last;
  assign out_free  = !out_valid || !out_stall;

  // Offset arithmetic shared by the walk decode.
  assign start_plus_len  = {1'b0, descriptor_start} + {9'd0, descriptor_length};
  assign offset_plus_one = {1'b0, byte_offset} + 17'd1;
  assign rel             = byte_offset - descriptor_start;
  assign in_walk  = (byte_offset >= usbpds_pkg::OFS_WALK_BEGIN) && !walk_stopped &&
                    (byte_offset < total_length) && (byte_offset >= descriptor_start);
  assign rel_zero = (byte_offset == descriptor_start);
  assign rel_one  = (rel == 16'd1);
  assign bad_length = (descriptor_length < usbpds_pkg::DESC_MIN_LEN) ||
                      (start_plus_len > {1'b0, total_length});
  assign desc_done  = in_walk && !rel_zero && !(rel_one && bad_length) &&
                      (offset_plus_one == start_plus_len);

  // Type and captured bytes as they stand once the current byte is taken.
  always_comb begin
    type_merged = rel_one ? desc_byte : descriptor_type;
    cap_merged  = captured_fields;
    for (int i = 0; i < usbpds_pkg::CAP_COUNT; i++) begin
      if (in_walk && rel == 16'(i + usbpds_pkg::CAP_BASE)) begin
        cap_merged[i] = desc_byte;
      end
    end
  end

  assign ep_mps = {cap_merged[3], cap_merged[2]};

  // Per-byte parse of the descriptor stream.
  always_comb begin
    byte_offset_next       = (byte_offset == usbpds_pkg::OFS_MAX) ? byte_offset
                                                                  : offset_plus_one[15:0];
    total_length_next      = total_length;
    header_length_next     = header_length;
    descriptor_start_next  = descriptor_start;
    descriptor_length_next = descriptor_length;
    descriptor_type_next   = descriptor_type;
    captured_fields_next   = captured_fields;
    walk_stopped_next      = walk_stopped;
    iface_found_next       = iface_found;
    latched_iface_next     = latched_iface;
    latched_out_ep_next    = latched_out_ep;
    latched_out_mps_next   = latched_out_mps;
    latched_in_ep_next     = latched_in_ep;
    latched_in_mps_next    = latched_in_mps;

    if (byte_offset == usbpds_pkg::OFS_HEADER_LEN) begin
      header_length_next    = desc_byte;
      descriptor_start_next = {8'd0, desc_byte};
      walk_stopped_next     = walk_stopped || (desc_byte < usbpds_pkg::HEADER_MIN_LEN);
    end else if (byte_offset == usbpds_pkg::OFS_TOTAL_LO) begin
      total_length_next = {total_length[15:8], desc_byte};
    end else if (byte_offset == usbpds_pkg::OFS_TOTAL_HI) begin
      total_length_next = {desc_byte, total_length[7:0]};
    end else if (in_walk) begin
      if (rel_zero) begin
        descriptor_length_next = desc_byte;
      end else begin
        descriptor_type_next = type_merged;
        captured_fields_next = cap_merged;
        if (rel_one && bad_length) begin
          walk_stopped_next = 1'b1;
        end
      end

      // Evaluate a completed descriptor and advance to the next one.
      if (desc_done) begin
        if (type_merged == usbpds_pkg::TYPE_INTERFACE &&
            descriptor_length >= usbpds_pkg::IFACE_MIN_LEN) begin
          if (cap_merged[3] == match_class && cap_merged[4] == match_subclass &&
              cap_merged[1] == 8'd0 && !iface_found) begin
            iface_found_next     = 1'b1;
            latched_iface_next   = cap_merged[0];
            latched_out_ep_next  = 8'd0;
            latched_out_mps_next = 16'd0;
            latched_in_ep_next   = 8'd0;
            latched_in_mps_next  = 16'd0;
          end
        end else if (type_merged == usbpds_pkg::TYPE_ENDPOINT &&
                     descriptor_length >= usbpds_pkg::EP_MIN_LEN) begin
          if (iface_found && cap_merged[1][1:0] == usbpds_pkg::XFER_BULK) begin
            if (!cap_merged[0][usbpds_pkg::DIR_IN_BIT]) begin
              if (latched_out_ep == 8'd0) begin
                latched_out_ep_next  = cap_merged[0];
                latched_out_mps_next = ep_mps;
              end
            end else if (latched_in_ep == 8'd0) begin
              latched_in_ep_next  = cap_merged[0];
              latched_in_mps_next = ep_mps;
            end
          end
        end
        descriptor_start_next  = start_plus_len[15:0];
        descriptor_length_next = 8'd0;
        descriptor_type_next   = 8'd0;
        captured_fields_next   = '0;
      end
    end
  end

  // Result formed from the state after the last byte.
  always_comb begin
    result.found = iface_found_next && (latched_out_ep_next != 8'd0);
    if (result.found) begin
      result.interface_number    = latched_iface_next;
      result.bulk_out_address    = latched_out_ep_next;
      result.bulk_out_max_packet = latched_out_mps_next;
      result.bulk_in_address     = latched_in_ep_next;
      result.bulk_in_max_packet  = latched_in_mps_next;
    end else begin
      result.interface_number    = 8'd0;
      result.bulk_out_address    = 8'd0;
      result.bulk_out_max_packet = 16'd0;
      result.bulk_in_address     = 8'd0;
      result.bulk_in_max_packet  = 16'd0;
    end
  end

  // Configuration and stream state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_class       <= usbpds_pkg::MATCH_CLASS_RESET;
      match_subclass    <= usbpds_pkg::MATCH_SUBCLASS_RESET;
      byte_offset       <= '0;
      total_length      <= '0;
      header_length     <= '0;
      descriptor_start  <= '0;
      descriptor_length <= '0;
      descriptor_type   <= '0;
      captured_fields   <= '0;
      walk_stopped      <= 1'b0;
      iface_found       <= 1'b0;
      latched_iface     <= '0;
      latched_out_ep    <= '0;
      latched_out_mps   <= '0;
      latched_in_ep     <= '0;
      latched_in_mps    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          usbpds_pkg::CFG_MATCH_CLASS:    match_class    <= cfg_data;
          usbpds_pkg::CFG_MATCH_SUBCLASS: match_subclass <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (last) begin
          byte_offset       <= '0;
          total_length      <= '0;
          header_length     <= '0;
          descriptor_start  <= '0;
          descriptor_length <= '0;
          descriptor_type   <= '0;
          captured_fields   <= '0;
          walk_stopped      <= 1'b0;
          iface_found       <= 1'b0;
          latched_iface     <= '0;
          latched_out_ep    <= '0;
          latched_out_mps   <= '0;
          latched_in_ep     <= '0;
          latched_in_mps    <= '0;
        end else begin
          byte_offset       <= byte_offset_next;
          total_length      <= total_length_next;
          header_length     <= header_length_next;
          descriptor_start  <= descriptor_start_next;
          descriptor_length <= descriptor_length_next;
          descriptor_type   <= descriptor_type_next;
          captured_fields   <= captured_fields_next;
          walk_stopped      <= walk_stopped_next;
          iface_found       <= iface_found_next;
          latched_iface     <= latched_iface_next;
          latched_out_ep    <= latched_out_ep_next;
          latched_out_mps   <= latched_out_mps_next;
          latched_in_ep     <= latched_in_ep_next;
          latched_in_mps    <= latched_in_mps_next;
        end
      end
    end
  end

  // Output register and skid entry valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : result;
    end
    if (!out_free && res_valid) begin
      skid_data <= result;
    end
  end

  assign found               = out_data.found;
  assign interface_number    = out_data.interface_number;
  assign bulk_out_address    = out_data.bulk_out_address;
  assign bulk_out_max_packet = out_data.bulk_out_max_packet;
  assign bulk_in_address     = out_data.bulk_in_address;
  assign bulk_in_max_packet  = out_data.bulk_in_max_packet;

`ifndef SYNTHESIS
  // The skid entry only fills behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  // The last byte returns the stream to its start.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (byte_offset == 16'd0 && !iface_found && !walk_stopped))
    else $error("stream state not cleared after the last byte");

  // A result without a match carries only zero fields.
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (interface_number == 8'd0 && bulk_out_address == 8'd0 &&
      bulk_out_max_packet == 16'd0 && bulk_in_address == 8'd0 &&
      bulk_in_max_packet == 16'd0))
    else $error("unmatched result has nonzero fields");

  // A stopped walk stays stopped until the stream ends.
  a_walk_stays_stopped: assert property (@(posedge clk) disable iff (rst)
    (walk_stopped && !(accept && last)) |=> walk_stopped)
    else $error("walk resumed inside a stream");

  // Stream position moves only on an accepted byte.
  a_offset_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(byte_offset))
    else $error("byte offset changed without an accepted byte");
`endif

endmodule
